@@ rtl/masked_box_smooth_3x3_assert.svh @@
// assertion macros for the masked 3x3 box smoothing block
// expects i_clk and i_rst_n in the including module
`ifndef MASKED_BOX_SMOOTH_3X3_ASSERT_SVH
`define MASKED_BOX_SMOOTH_3X3_ASSERT_SVH

`ifndef ASSERT_OFF
`define MSM_ASSERT(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);
`define MSM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define MSM_ASSERT(label, expr, msg)
`define MSM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

@@ rtl/msm_pkg.sv @@
// shared constants, types and the reciprocal table of the masked 3x3 box smoother
// no dependencies
package msm_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int SAMPLE_BITS = 16;
    localparam int NUM_CH      = 4;
    localparam int WIN         = 9;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WIDTH_W     = 12;
    localparam int HEIGHT_W    = 16;
    localparam int CHAN_W      = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int PIXEL_W     = NUM_CH * SAMPLE_BITS;
    localparam int SUM_W       = SAMPLE_BITS + 4;
    localparam int CNT_W       = 4;
    localparam int RECIP_SHIFT = 23;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int QUOT_W      = SAMPLE_BITS + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd2;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;
    typedef t_sample [NUM_CH-1:0] t_pixel;
    typedef logic [WIN-1:0] t_nbr;

    typedef struct packed {
        logic sum_en;
        logic mul_en;
    } t_lane_ctl;

    typedef struct packed {
        logic top_ok;
        logic bottom_ok;
        logic left_ok;
        logic right_ok;
    } t_border;

    typedef struct packed {
        logic                          action;
        logic signed [SAMPLE_BITS-1:0] pixel_ch0;
        logic signed [SAMPLE_BITS-1:0] pixel_ch1;
        logic signed [SAMPLE_BITS-1:0] pixel_ch2;
        logic signed [SAMPLE_BITS-1:0] pixel_ch3;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] out_ch0;
        logic signed [SAMPLE_BITS-1:0] out_ch1;
        logic signed [SAMPLE_BITS-1:0] out_ch2;
        logic signed [SAMPLE_BITS-1:0] out_ch3;
        logic                          end_of_image;
    } t_out_beat;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_SUM  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    // ceil(2^RECIP_SHIFT / n), exact floor division for |sum| below 2^19
    function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] r;
        case (n)
            4'd1:    r = 24'd8388608;
            4'd2:    r = 24'd4194304;
            4'd3:    r = 24'd2796203;
            4'd4:    r = 24'd2097152;
            4'd5:    r = 24'd1677722;
            4'd6:    r = 24'd1398102;
            4'd7:    r = 24'd1198373;
            4'd8:    r = 24'd1048576;
            4'd9:    r = 24'd932068;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/msm_ram.sv @@
// generic single write, single read port ram with registered read data
// no dependencies
module msm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/msm_lane.sv @@
// one channel lane: masked window sum, then divide by multiplying with a reciprocal
// depends on msm_pkg
module msm_lane
    import msm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_used,
    input  t_lane_ctl            i_ctl,
    input  t_sample [WIN-1:0]    i_smp,
    input  t_nbr                 i_mask,
    input  logic [RECIP_W-1:0]   i_recip,
    output t_nbr                 o_pos,
    output t_sample              o_result
);

    logic signed [SUM_W-1:0] w_sum;
    logic signed [SUM_W-1:0] r_sum;
    logic [SUM_W-1:0]        w_abs;
    logic [PROD_W-1:0]       w_prod;
    logic [PROD_W-1:0]       r_prod;
    logic                    r_neg;
    logic [QUOT_W-1:0]       w_quot;
    logic [QUOT_W-1:0]       w_signed_quot;

    always_comb begin
        for (int n = 0; n < WIN; n++) begin
            o_pos[n] = i_used && ($signed(i_smp[n]) > $signed(SAMPLE_BITS'(0)));
        end
    end

    always_comb begin
        w_sum = '0;
        for (int n = 0; n < WIN; n++) begin
            if (i_mask[n]) begin
                w_sum = w_sum + SUM_W'($signed(i_smp[n]));
            end
        end
    end

    assign w_abs  = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
    assign w_prod = PROD_W'(w_abs) * PROD_W'(i_recip);

    always_ff @(posedge i_clk) begin
        if (i_ctl.sum_en) begin
            r_sum <= w_sum;
        end
        if (i_ctl.mul_en) begin
            r_prod <= w_prod;
            r_neg  <= r_sum[SUM_W-1];
        end
    end

    assign w_quot        = r_prod[RECIP_SHIFT +: QUOT_W];
    assign w_signed_quot = r_neg ? QUOT_W'(-w_quot) : w_quot;
    assign o_result      = i_used ? t_sample'(w_signed_quot[SAMPLE_BITS-1:0]) : '0;

endmodule

@@ rtl/msm_merge.sv @@
// merges lane findings: neighbor mask from borders and positive samples, count reciprocal
// depends on msm_pkg
module msm_merge
    import msm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_load,
    input  t_border              i_border,
    input  t_nbr [NUM_CH-1:0]    i_pos,
    output t_nbr                 o_mask,
    output logic [RECIP_W-1:0]   o_recip
);

    t_nbr               w_any;
    t_nbr               w_in_image;
    logic [CNT_W-1:0]   w_count;
    logic [RECIP_W-1:0] r_recip;

    always_comb begin
        for (int n = 0; n < WIN; n++) begin
            w_any[n] = 1'b0;
            for (int c = 0; c < NUM_CH; c++) begin
                w_any[n] = w_any[n] | i_pos[c][n];
            end
        end
    end

    // rows: 0 above, 1 center, 2 below; columns: 0 left, 1 center, 2 right
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                w_in_image[r*3+k] = (r != 0 || i_border.top_ok)
                                 && (r != 2 || i_border.bottom_ok)
                                 && (k != 0 || i_border.left_ok)
                                 && (k != 2 || i_border.right_ok);
            end
        end
    end

    assign o_mask = w_any & w_in_image;

    always_comb begin
        w_count = '0;
        for (int n = 0; n < WIN; n++) begin
            w_count = w_count + CNT_W'(o_mask[n]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_recip <= recip_of(w_count);
        end
    end

    assign o_recip = r_recip;

endmodule

@@ rtl/masked_box_smooth_3x3.sv @@
// top level of the masked 3x3 box smoother: sequencer, window, line stores, output register
// depends on msm_pkg, msm_ram, msm_lane, msm_merge and masked_box_smooth_3x3_assert.svh
//
//  port group   dir   handshake                   payload
//  pixel in     in    i_in_valid / o_in_stall     i_in_beat (t_in_beat)
//  result out   out   o_out_valid / i_out_stall   o_out_beat (t_out_beat)
//  config       in    i_cfg_wr_en                 i_cfg_index, i_cfg_data
//
//  an item that gives no result steps through accept, then line store read and window shift
//  an item with a result steps through accept, read, lane sums, lane multiply, output load
//  these steps follow from the registered line store read and the sum/multiply lane stages
//  reset clears counters, window and out valid; line stores hold garbage until written
//  a stalled result holds the sequencer at output load; the next beat waits behind it
`include "masked_box_smooth_3x3_assert.svh"

module masked_box_smooth_3x3
    import msm_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in_beat                i_in_beat,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out_beat               o_out_beat,
    input  logic                    i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data
);

    t_state                 r_state;
    t_state                 n_state;
    logic [WIDTH_W-1:0]     r_cfg_width;
    logic [HEIGHT_W-1:0]    r_cfg_height;
    logic [CHAN_W-1:0]      r_cfg_chan;
    logic [COL_W-1:0]       r_in_col;
    logic [1:0]             r_in_row;
    logic [COL_W-1:0]       r_out_col;
    logic [HEIGHT_W-1:0]    r_out_row;
    logic                   r_out_valid;
    t_pixel                 r_win [3][3];
    t_pixel                 r_pix;
    logic [COL_W-1:0]       r_x;
    logic                   r_emit;
    logic                   r_eoi;
    t_out_beat              r_out;

    logic [WIDTH_W-1:0]     w_width;
    logic [HEIGHT_W-1:0]    w_height;
    logic [CHAN_W-1:0]      w_chan;
    logic [NUM_CH-1:0]      w_used;
    t_sample [NUM_CH-1:0]   w_in_smp;
    logic                   w_accept;
    logic [COL_W-1:0]       w_x;
    logic [WIDTH_W-1:0]     w_in_col_inc;
    logic                   w_emit;
    t_border                w_border;
    logic                   w_eoi;
    logic                   w_out_free;
    logic                   w_out_load;
    logic                   w_cfg_hit;
    t_lane_ctl              w_lane_ctl;
    t_nbr [NUM_CH-1:0]      w_pos;
    t_nbr                   w_mask;
    logic [RECIP_W-1:0]     w_recip;
    t_sample [NUM_CH-1:0]   w_res;
    logic [PIXEL_W-1:0]     w_older_q;
    logic [PIXEL_W-1:0]     w_newer_q;
    logic                   w_ram_wr;

    always_comb begin
        if (r_cfg_width == '0) begin
            w_width = WIDTH_W'(1);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            w_width = WIDTH_W'(MAX_WIDTH);
        end else begin
            w_width = r_cfg_width;
        end
        w_height = (r_cfg_height == '0) ? HEIGHT_W'(1) : r_cfg_height;
        if (r_cfg_chan == '0) begin
            w_chan = CHAN_W'(1);
        end else if (32'(r_cfg_chan) > NUM_CH) begin
            w_chan = CHAN_W'(NUM_CH);
        end else begin
            w_chan = r_cfg_chan;
        end
        for (int c = 0; c < NUM_CH; c++) begin
            w_used[c] = 32'(c) < 32'(w_chan);
        end
    end

    assign w_in_smp[0] = i_in_beat.pixel_ch0;
    assign w_in_smp[1] = i_in_beat.pixel_ch1;
    assign w_in_smp[2] = i_in_beat.pixel_ch2;
    assign w_in_smp[3] = i_in_beat.pixel_ch3;

    assign o_in_stall   = (r_state != ST_IDLE);
    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_x          = (WIDTH_W'(r_in_col) >= w_width) ? '0 : r_in_col;
    assign w_in_col_inc = WIDTH_W'(w_x) + WIDTH_W'(1);
    assign w_emit       = (r_in_row == 2'd2) || (r_in_row == 2'd1 && r_in_col != '0);

    assign w_border.top_ok    = (r_out_row != '0);
    assign w_border.bottom_ok = ({1'b0, r_out_row} + (HEIGHT_W+1)'(1)) < {1'b0, w_height};
    assign w_border.left_ok   = (r_out_col != '0);
    assign w_border.right_ok  = (WIDTH_W'(r_out_col) + WIDTH_W'(1)) < w_width;
    assign w_eoi              = !w_border.right_ok && !w_border.bottom_ok;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_out_load = (r_state == ST_OUT) && w_out_free;
    assign w_ram_wr   = (r_state == ST_READ);

    assign w_cfg_hit = i_cfg_wr_en && (i_cfg_index == CFG_IMAGE_WIDTH
                                    || i_cfg_index == CFG_IMAGE_HEIGHT
                                    || i_cfg_index == CFG_CHANNEL_COUNT);

    assign w_lane_ctl.sum_en = (r_state == ST_SUM);
    assign w_lane_ctl.mul_en = (r_state == ST_MUL);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = r_emit ? ST_SUM : ST_IDLE;
            end
            ST_SUM: begin
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cfg_width  <= WIDTH_W'(2048);
            r_cfg_height <= HEIGHT_W'(1);
            r_cfg_chan   <= CHAN_W'(4);
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_out_valid  <= 1'b0;
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    r_win[r][k] <= '0;
                end
            end
        end else begin
            r_state <= n_state;

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            if (w_accept) begin
                if (w_in_col_inc >= w_width) begin
                    r_in_col <= '0;
                    if (r_in_row != 2'd2) begin
                        r_in_row <= r_in_row + 2'd1;
                    end
                end else begin
                    r_in_col <= w_in_col_inc[COL_W-1:0];
                end
            end

            if (r_state == ST_READ) begin
                for (int r = 0; r < 3; r++) begin
                    r_win[r][0] <= r_win[r][1];
                    r_win[r][1] <= r_win[r][2];
                end
                r_win[0][2] <= t_pixel'(w_older_q);
                r_win[1][2] <= t_pixel'(w_newer_q);
                r_win[2][2] <= r_pix;
            end

            if (r_state == ST_SUM) begin
                if (!w_border.right_ok) begin
                    r_out_col <= '0;
                    r_out_row <= r_out_row + HEIGHT_W'(1);
                end else begin
                    r_out_col <= r_out_col + COL_W'(1);
                end
            end

            // end of image or a write to a defined config register restarts the stream
            if ((r_state == ST_SUM && w_eoi) || w_cfg_hit) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
                for (int r = 0; r < 3; r++) begin
                    for (int k = 0; k < 3; k++) begin
                        r_win[r][k] <= '0;
                    end
                end
            end

            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_IMAGE_WIDTH:   r_cfg_width  <= i_cfg_data[WIDTH_W-1:0];
                    CFG_IMAGE_HEIGHT:  r_cfg_height <= i_cfg_data[HEIGHT_W-1:0];
                    CFG_CHANNEL_COUNT: r_cfg_chan   <= i_cfg_data[CHAN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int c = 0; c < NUM_CH; c++) begin
                r_pix[c] <= (!i_in_beat.action && w_used[c]) ? w_in_smp[c] : '0;
            end
            r_x    <= w_x;
            r_emit <= w_emit;
        end
        if (r_state == ST_SUM) begin
            r_eoi <= w_eoi;
        end
        if (w_out_load) begin
            r_out.out_ch0      <= w_res[0];
            r_out.out_ch1      <= w_res[1];
            r_out.out_ch2      <= w_res[2];
            r_out.out_ch3      <= w_res[3];
            r_out.end_of_image <= r_eoi;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    // row y-2 store
    msm_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram_older (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_wr),
        .i_wr_addr (r_x),
        .i_wr_data (w_newer_q),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_x),
        .o_rd_data (w_older_q)
    );

    // row y-1 store
    msm_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (MAX_WIDTH)
    ) u_ram_newer (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_wr),
        .i_wr_addr (r_x),
        .i_wr_data (PIXEL_W'(r_pix)),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_x),
        .o_rd_data (w_newer_q)
    );

    for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
        t_sample [WIN-1:0] w_smp;

        for (genvar n = 0; n < WIN; n++) begin : g_tap
            assign w_smp[n] = r_win[n / 3][n % 3][c];
        end

        msm_lane u_lane (
            .i_clk    (i_clk),
            .i_used   (w_used[c]),
            .i_ctl    (w_lane_ctl),
            .i_smp    (w_smp),
            .i_mask   (w_mask),
            .i_recip  (w_recip),
            .o_pos    (w_pos[c]),
            .o_result (w_res[c])
        );
    end

    msm_merge u_merge (
        .i_clk    (i_clk),
        .i_load   (w_lane_ctl.sum_en),
        .i_border (w_border),
        .i_pos    (w_pos),
        .o_mask   (w_mask),
        .o_recip  (w_recip)
    );

    `MSM_ASSERT(a_in_col_range, WIDTH_W'(r_in_col) < w_width, "input column beyond row width")
    `MSM_ASSERT(a_out_row_range, r_out_row < w_height, "output row beyond image height")
    `MSM_ASSERT_NEXT(a_hold_result, (r_state == ST_OUT) && r_out_valid && i_out_stall, r_state == ST_OUT, "result step left while output busy")
    `MSM_ASSERT_NEXT(a_restart_on_eoi, (r_state == ST_SUM) && w_eoi, (r_in_col == '0) && (r_out_row == '0) && (r_out_col == '0), "stream not restarted after last pixel")

endmodule
